FILE: design/pqls_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pqls_pkg: shared sizes and types of the pq lookup score engine
// table geometry, word widths and the registered write-port bundle
// ----------------------------------------------------------------------------
package pqls_pkg;

   localparam int SUBSPACES   = 16;
   localparam int CENTROIDS   = 256;
   localparam int VALUE_WIDTH = 32;

   localparam int TABLE_DEPTH = SUBSPACES * CENTROIDS;
   localparam int INDEX_WIDTH = 12;
   localparam int IN_WIDTH    = 32;
   localparam int CODE_WIDTH  = 8;
   localparam int CODES_WIDTH = 64;
   localparam int SCORE_WIDTH = 36;
   localparam int CENT_AW     = (CENTROIDS > 1) ? $clog2(CENTROIDS) : 1;

   // adder tree always runs sixteen lanes, unused lanes carry zero
   localparam int TREE_LANES  = 16;
   localparam int TREE_QUADS  = TREE_LANES / 4;
   localparam int QUAD_WIDTH  = VALUE_WIDTH + 2;
   localparam int SUM_WIDTH   = VALUE_WIDTH + 4;
   localparam int WIDE_WIDTH  = ((SUM_WIDTH > SCORE_WIDTH) ? SUM_WIDTH : SCORE_WIDTH) + 1;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic signed [SCORE_WIDTH-1:0] score_type;

   typedef struct packed {
      logic [SUBSPACES-1:0] bank_en;
      logic [CENT_AW-1:0]   addr;
      value_type            data;
   } pqls_wr_type;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_SCORE = 1'b1;

endpackage
`default_nettype wire

FILE: design/pq_lut_score_sum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pq_lut_score_sum: product-quantization lookup score engine
// a write beat loads one table word, a score beat sums one entry per subspace
// ----------------------------------------------------------------------------
// a score beat passes s1_valid_ff, s2_valid_ff and the tree valid regs to rsp_strobe
// throughput: one beat per cycle, write or score, set by the banked table (sixteen
//    banks, one write and one read port each, read once per cycle) and the two-level adder tree
// busy stays low: the receiver cannot stall and every stage advances each cycle
// reset clears only the valid bits and write enables; table words stay
//    undefined until written, so no clearing pass runs
module pq_lut_score_sum
   import pqls_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic                    req_op,
   input  wire logic [INDEX_WIDTH-1:0]  req_table_index,
   input  wire logic signed [IN_WIDTH-1:0] req_table_value,
   input  wire logic [CODES_WIDTH-1:0]  req_codes_low,
   input  wire logic [CODES_WIDTH-1:0]  req_codes_high,
   output logic                         rsp_strobe,
   output score_type                    rsp_score
);

   // no back-pressure anywhere: a beat is taken whenever start is high
   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // ---- stage 1: decode the beat -------------------------------------------
   logic [2*CODES_WIDTH-1:0] codes_all;
   value_type                value_sat;
   pqls_wr_type              s1_wr_in;
   pqls_wr_type              s1_wr_ff;
   logic                     s1_valid_in;
   logic                     s1_valid_ff;
   logic [CENT_AW-1:0]       s1_code_in [SUBSPACES];
   logic [CENT_AW-1:0]       s1_code_ff [SUBSPACES];

   assign codes_all = {req_codes_high, req_codes_low};

   // table words narrower than the input saturate, wider ones sign-extend
   generate
      if (VALUE_WIDTH < IN_WIDTH) begin : g_value_clamp
         localparam logic signed [IN_WIDTH-1:0] VMAX =
            {{(IN_WIDTH-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
         localparam logic signed [IN_WIDTH-1:0] VMIN =
            {{(IN_WIDTH-VALUE_WIDTH+1){1'b1}}, {(VALUE_WIDTH-1){1'b0}}};
         always_comb begin
            if (req_table_value > VMAX) begin
               value_sat = VMAX[VALUE_WIDTH-1:0];
            end else if (req_table_value < VMIN) begin
               value_sat = VMIN[VALUE_WIDTH-1:0];
            end else begin
               value_sat = req_table_value[VALUE_WIDTH-1:0];
            end
         end
      end else begin : g_value_ext
         assign value_sat = VALUE_WIDTH'(req_table_value);
      end
   endgenerate

   // bank select by range compare, one compare per bank; out-of-range writes hit none
   always_comb begin
      s1_wr_in.bank_en = '0;
      s1_wr_in.addr    = '0;
      s1_wr_in.data    = value_sat;
      for (int i = 0; i < SUBSPACES; i++) begin
         if (accept && (req_op == OP_WRITE)
             && ({1'b0, req_table_index} >= (INDEX_WIDTH+1)'(i*CENTROIDS))
             && ({1'b0, req_table_index} < (INDEX_WIDTH+1)'((i+1)*CENTROIDS))) begin
            s1_wr_in.bank_en[i] = 1'b1;
            s1_wr_in.addr = s1_wr_in.addr
               | CENT_AW'(req_table_index - INDEX_WIDTH'(i*CENTROIDS));
         end
      end
   end

   // codes above the table row length pin to the last centroid
   always_comb begin
      for (int i = 0; i < SUBSPACES; i++) begin
         if ({1'b0, codes_all[CODE_WIDTH*i +: CODE_WIDTH]} >= (CODE_WIDTH+1)'(CENTROIDS)) begin
            s1_code_in[i] = CENT_AW'(CENTROIDS - 1);
         end else begin
            s1_code_in[i] = CENT_AW'(codes_all[CODE_WIDTH*i +: CODE_WIDTH]);
         end
      end
   end

   assign s1_valid_in = accept && (req_op == OP_SCORE);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         s1_wr_ff.bank_en <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s1_wr_ff    <= s1_wr_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_code_ff <= s1_code_in;
   end

   // ---- stage 2: banked table lookup ---------------------------------------
   // a write lands in its bank from s1_wr_ff, and a following score beat reads the new word
   logic      s2_valid_ff;
   value_type bank_rd [SUBSPACES];
   value_type lanes [TREE_LANES];

   generate
      for (genvar b = 0; b < SUBSPACES; b++) begin : g_bank
         pqls_bank_ram #(
            .DEPTH      (CENTROIDS),
            .ADDR_WIDTH (CENT_AW),
            .DATA_WIDTH (VALUE_WIDTH)
         ) u_bank (
            .clock   (clock),
            .wr_en   (s1_wr_ff.bank_en[b]),
            .wr_addr (s1_wr_ff.addr),
            .wr_data (s1_wr_ff.data),
            .rd_en   (s1_valid_ff),
            .rd_addr (s1_code_ff[b]),
            .rd_data (bank_rd[b])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // pad the tree out to sixteen lanes
   always_comb begin
      for (int i = 0; i < TREE_LANES; i++) begin
         lanes[i] = '0;
      end
      for (int i = 0; i < SUBSPACES; i++) begin
         lanes[i] = bank_rd[i];
      end
   end

   // ---- stages 3 and 4: adder tree and saturation --------------------------
   pqls_sum_tree u_tree (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_lanes  (lanes),
      .out_valid (rsp_strobe),
      .out_score (rsp_score)
   );

endmodule
`default_nettype wire

FILE: design/pqls_bank_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pqls_bank_ram: one table bank
// single write port, single read port with registered read data
// ----------------------------------------------------------------------------
module pqls_bank_ram #(
   parameter int DEPTH      = 256,
   parameter int ADDR_WIDTH = 8,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_WIDTH-1:0] wr_addr,
   input  wire logic [DATA_WIDTH-1:0] wr_data,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_WIDTH-1:0] rd_addr,
   output logic      [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] store_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: design/pqls_sum_tree.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pqls_sum_tree: two-stage registered adder tree
// sixteen lanes to four quad sums, then to one saturated score
// ----------------------------------------------------------------------------
module pqls_sum_tree
   import pqls_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   input  wire value_type in_lanes [TREE_LANES],
   output logic           out_valid,
   output score_type      out_score
);

   localparam logic signed [WIDE_WIDTH-1:0] SCORE_MAX =
      {{(WIDE_WIDTH-SCORE_WIDTH+1){1'b0}}, {(SCORE_WIDTH-1){1'b1}}};
   localparam logic signed [WIDE_WIDTH-1:0] SCORE_MIN =
      {{(WIDE_WIDTH-SCORE_WIDTH+1){1'b1}}, {(SCORE_WIDTH-1){1'b0}}};

   logic                         quad_valid_ff;
   logic signed [QUAD_WIDTH-1:0] quad_ff [TREE_QUADS];
   logic signed [QUAD_WIDTH-1:0] quad_in [TREE_QUADS];
   logic signed [SUM_WIDTH-1:0]  total;
   logic signed [WIDE_WIDTH-1:0] total_wide;
   score_type                    score_in;
   score_type                    score_ff;
   logic                         valid_ff;

   always_comb begin
      for (int q = 0; q < TREE_QUADS; q++) begin
         quad_in[q] = QUAD_WIDTH'(in_lanes[4*q])   + QUAD_WIDTH'(in_lanes[4*q+1])
                    + QUAD_WIDTH'(in_lanes[4*q+2]) + QUAD_WIDTH'(in_lanes[4*q+3]);
      end
   end

   always_comb begin
      total = '0;
      for (int q = 0; q < TREE_QUADS; q++) begin
         total = total + SUM_WIDTH'(quad_ff[q]);
      end
      total_wide = WIDE_WIDTH'(total);
      if (total_wide > SCORE_MAX) begin
         score_in = SCORE_MAX[SCORE_WIDTH-1:0];
      end else if (total_wide < SCORE_MIN) begin
         score_in = SCORE_MIN[SCORE_WIDTH-1:0];
      end else begin
         score_in = total_wide[SCORE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quad_valid_ff <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         quad_valid_ff <= in_valid;
         valid_ff      <= quad_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      quad_ff  <= quad_in;
      score_ff <= score_in;
   end

   assign out_valid = valid_ff;
   assign out_score = score_ff;

endmodule
`default_nettype wire
